/* rtl/core/xrg_pkg.sv */
// Shared types, constants and helper functions for the xoshiro128** generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package xrg_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [WordW-1:0] GOLDEN_STEP = 32'h9E3779B9;
    localparam logic [WordW-1:0] FIN_MUL_A   = 32'h21F0AAAD;
    localparam logic [WordW-1:0] FIN_MUL_B   = 32'h735A2D97;
    localparam logic [WordW-1:0] STAR_MUL_A  = 32'd5;
    localparam logic [WordW-1:0] STAR_MUL_B  = 32'd9;

    typedef enum logic [1:0] {
        CMD_RESEED  = 2'd0,
        CMD_RAW     = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_MIX     = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_CUT,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_DRAW_C,
        ST_MOD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [WordW-1:0] remainder;
    } rem_rsp_t;

    // splitmix32 finaliser; only evaluated at elaboration for reset values
    function automatic logic [WordW-1:0] fin32(input logic [WordW-1:0] v_in);
        logic [WordW-1:0] v;
        v = v_in;
        v = v ^ (v >> 16);
        v = v * FIN_MUL_A;
        v = v ^ (v >> 15);
        v = v * FIN_MUL_B;
        v = v ^ (v >> 15);
        return v;
    endfunction

    // state after reset: expansion of a zero seed
    localparam logic [WordW-1:0] RST_W0 = fin32(GOLDEN_STEP);
    localparam logic [WordW-1:0] RST_W1 = fin32(WordW'(GOLDEN_STEP * 2));
    localparam logic [WordW-1:0] RST_W2 = fin32(WordW'(GOLDEN_STEP * 3));
    localparam logic [WordW-1:0] RST_W3 = fin32(WordW'(GOLDEN_STEP * 4));

endpackage

/* rtl/core/xoshiro128ss_random_generator_top.sv */
// Top level of the xoshiro128** generator: sequencer, state words, output register.
// Depends on xrg_pkg, xrg_mul and xrg_rem.
`timescale 1ns / 1ps

// xoshiro128** random word generator. Each input beat carries a command in
// s_axis_tuser and gives exactly one output beat. One shared registered
// multiplier does every multiply (finaliser and starstar scramble), and one
// bit-serial remainder unit does every modulo, so the block takes one beat
// at a time and is not ready while a command runs. A mix runs one finaliser
// pass, a raw draw one scramble and state step, and a reseed four finaliser
// passes; a bounded draw computes the threshold remainder, draws again while
// a draw falls below the threshold, then takes the final remainder; bound
// zero goes straight to the output with bad_bound set. The remainder unit
// works through 32 serial steps. The output register holds a finished result
// while the next command is taken; a result waits in the sequencer only if
// the previous one is still not taken. seed_word is written via seed_word_we
// and only takes effect on the next reseed command; the state after reset is
// the expansion of a zero seed.
module xoshiro128ss_random_generator_top
    import xrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        seed_word_we,
    input  logic [31:0] seed_word_wdata,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] bound, [63:32] mix_input
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_word
    output logic [0:0]  m_axis_tuser    // [0] bad_bound
);

    state_t           state_reg, state_next;
    logic [WordW-1:0] seed_reg;
    logic [WordW-1:0] w_reg [4];
    logic [WordW-1:0] w_next [4];
    logic [WordW-1:0] acc_reg, acc_next;
    logic [WordW-1:0] val_reg, val_next;
    logic [WordW-1:0] lim_reg, lim_next;
    logic [WordW-1:0] cut_reg, cut_next;
    logic [WordW-1:0] res_reg, res_next;
    logic             flag_reg, flag_next;
    cmd_t             cmd_reg, cmd_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic             m_valid_reg, m_valid_next;
    logic [WordW-1:0] m_data_reg, m_data_next;
    logic             m_user_reg, m_user_next;

    logic             accept;
    logic             out_free;
    cmd_t             in_cmd;
    logic [WordW-1:0] in_bound;
    logic [WordW-1:0] in_mix;

    mul_req_t         mul_req;
    logic [WordW-1:0] prod;
    rem_req_t         rem_req;
    rem_rsp_t         rem_rsp;

    logic [WordW-1:0] fin_b_op;
    logic [WordW-1:0] fin_word;
    logic [WordW-1:0] m2;
    logic [WordW-1:0] m3;
    logic             draw_low;

    assign in_cmd   = cmd_t'(s_axis_tuser);
    assign in_bound = s_axis_tdata[31:0];
    assign in_mix   = s_axis_tdata[63:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign fin_b_op = prod ^ (prod >> 15);
    assign fin_word = prod ^ (prod >> 15);
    assign m2       = w_reg[2] ^ w_reg[0];
    assign m3       = w_reg[3] ^ w_reg[1];
    assign draw_low = prod < cut_reg;

    xrg_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    xrg_rem u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_RESEED, CMD_MIX: state_next = ST_FIN_A;
                        CMD_RAW:             state_next = ST_DRAW_A;
                        CMD_BOUNDED:         state_next = (in_bound == '0) ? ST_OUT : ST_CUT;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIN_A:  state_next = ST_FIN_B;
            ST_FIN_B:  state_next = ST_FIN_C;
            ST_FIN_C:
            begin
                if (cmd_reg == CMD_RESEED && cnt_reg != 2'd3)
                    state_next = ST_FIN_A;
                else
                    state_next = ST_OUT;
            end
            ST_CUT:    state_next = rem_rsp.done ? ST_DRAW_A : ST_CUT;
            ST_DRAW_A: state_next = ST_DRAW_B;
            ST_DRAW_B: state_next = ST_DRAW_C;
            ST_DRAW_C:
            begin
                if (cmd_reg == CMD_RAW)
                    state_next = ST_OUT;
                else if (draw_low)
                    state_next = ST_DRAW_A;
                else
                    state_next = ST_MOD;
            end
            ST_MOD:    state_next = rem_rsp.done ? ST_OUT : ST_MOD;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            w_next[i] = w_reg[i];
        end
        acc_next     = acc_reg;
        val_next     = val_reg;
        lim_next     = lim_reg;
        cut_next     = cut_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        mul_req.a        = val_reg ^ (val_reg >> 16);
        mul_req.b        = FIN_MUL_A;
        rem_req.start    = 1'b0;
        rem_req.dividend = WordW'(0) - lim_reg;
        rem_req.divisor  = lim_reg;

        // drop the output beat once taken
        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = in_cmd;
                    lim_next  = in_bound;
                    cnt_next  = '0;
                    res_next  = '0;
                    flag_next = 1'b0;
                    if (in_cmd == CMD_RESEED)
                    begin
                        acc_next = seed_reg + GOLDEN_STEP;
                        val_next = seed_reg + GOLDEN_STEP;
                    end
                    else
                    begin
                        val_next = in_mix;
                    end
                    if (in_cmd == CMD_BOUNDED)
                    begin
                        if (in_bound == '0)
                        begin
                            flag_next = 1'b1;
                        end
                        else
                        begin
                            // threshold (2^32 - bound) mod bound
                            rem_req.start    = 1'b1;
                            rem_req.dividend = WordW'(0) - in_bound;
                            rem_req.divisor  = in_bound;
                        end
                    end
                end
            end
            ST_FIN_A:
            begin
                mul_req.a = val_reg ^ (val_reg >> 16);
                mul_req.b = FIN_MUL_A;
            end
            ST_FIN_B:
            begin
                mul_req.a = fin_b_op;
                mul_req.b = FIN_MUL_B;
            end
            ST_FIN_C:
            begin
                if (cmd_reg == CMD_RESEED)
                begin
                    w_next[cnt_reg] = fin_word;
                    if (cnt_reg == 2'd3)
                    begin
                        // all-zero state would be stuck; force word 0 to one
                        if ((w_reg[0] | w_reg[1] | w_reg[2] | fin_word) == '0)
                            w_next[0] = WordW'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        acc_next = acc_reg + GOLDEN_STEP;
                        val_next = acc_reg + GOLDEN_STEP;
                    end
                end
                else
                begin
                    res_next = fin_word;
                end
            end
            ST_CUT:
            begin
                if (rem_rsp.done)
                    cut_next = rem_rsp.remainder;
            end
            ST_DRAW_A:
            begin
                // scramble word 1 and advance the state together
                mul_req.a = w_reg[1];
                mul_req.b = STAR_MUL_A;
                w_next[0] = w_reg[0] ^ m3;
                w_next[1] = w_reg[1] ^ m2;
                w_next[2] = m2 ^ (w_reg[1] << 9);
                w_next[3] = {m3[20:0], m3[31:21]};
            end
            ST_DRAW_B:
            begin
                mul_req.a = {prod[24:0], prod[31:25]};
                mul_req.b = STAR_MUL_B;
            end
            ST_DRAW_C:
            begin
                if (cmd_reg == CMD_RAW)
                begin
                    res_next = prod;
                end
                else if (!draw_low)
                begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = prod;
                    rem_req.divisor  = lim_reg;
                end
            end
            ST_MOD:
            begin
                if (rem_rsp.done)
                    res_next = rem_rsp.remainder;
            end
            ST_OUT:
            begin
                // load the result once the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            seed_reg    <= '0;
            w_reg[0]    <= RST_W0;
            w_reg[1]    <= RST_W1;
            w_reg[2]    <= RST_W2;
            w_reg[3]    <= RST_W3;
            cmd_reg     <= CMD_RESEED;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (seed_word_we)
                seed_reg <= seed_word_wdata;
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= w_next[i];
            end
            cmd_reg     <= cmd_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        lim_reg    <= lim_next;
        cut_reg    <= cut_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

endmodule

/* rtl/core/xrg_mul.sv */
// Shared 32x32 multiplier, low word kept, one register stage.
// Depends on xrg_pkg for the operand struct.
`timescale 1ns / 1ps

module xrg_mul
    import xrg_pkg::*;
(
    input  logic             clk,
    input  mul_req_t         req,
    output logic [WordW-1:0] prod
);

    logic [WordW-1:0] prod_reg;
    logic [WordW-1:0] prod_next;

    assign prod_next = req.a * req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/xrg_rem.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle while busy.
// Depends on xrg_pkg for the request and response structs.
`timescale 1ns / 1ps

module xrg_rem
    import xrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [WordW-1:0] rem_reg, rem_next;
    logic [WordW-1:0] quo_reg, quo_next;
    logic [WordW-1:0] div_reg, div_next;
    logic [WordW:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[WordW-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract if it fits
            rem_next = fits ? WordW'(trial - {1'b0, div_reg}) : trial[WordW-1:0];
            quo_next = {quo_reg[WordW-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
